// ----- rtl/ray_box_slab_test_macros.svh -----
// Assertion macros for the ray/box slab test block.
// Included by RTL files that carry concurrent assertions.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RBST_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBST_ASSERT(lbl, clk, rstn, prop, msg)
`define RBST_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/rbst_pkg.sv -----
// Package for the ray/box slab test: register map, reset values, t constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS       = 16;
  localparam int ADDR_W          = 5;
  localparam int NUM_REGS        = 6;

  typedef enum logic [2:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_A_Z = 3'd2,
    REG_B_X = 3'd3,
    REG_B_Y = 3'd4,
    REG_B_Z = 3'd5
  } reg_idx_e;

  localparam int CORNER_RST [NUM_REGS] = '{-32768, -32768, -65536, 32768, 32768, -196608};

  // t values are kept 33 bits wide so the unbounded interval lies outside Q16.16
  localparam logic signed [32:0] T_MAX    = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] T_MIN    = 33'sh1_8000_0000;
  localparam logic signed [32:0] T_UNB_LO = 33'sh1_0000_0000;
  localparam logic signed [32:0] T_UNB_HI = 33'sh0_FFFF_FFFF;

  typedef struct packed {
    logic [2:0] neg_a;
    logic [2:0] neg_b;
    logic [2:0] unb;
    logic [2:0] miss;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/rbst_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes (num * 2^16) / den; uses rbst_pkg for the fraction width.
`timescale 1ns / 1ps
`default_nettype none
module rbst_div #(
  parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [W-1:0]                      num_i,
  input  logic [W-1:0]                      den_i,
  output logic [W+rbst_pkg::FRAC_BITS-1:0]  quo_o
);
  import rbst_pkg::*;

  localparam int NQ = W + FRAC_BITS;

  logic [W-1:0]  rem_q [NQ];
  logic [NQ-1:0] num_q [NQ];
  logic [NQ-1:0] quo_q [NQ];
  logic [W-1:0]  den_q [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    logic [W-1:0]  rem_p;
    logic [NQ-1:0] num_p;
    logic [NQ-1:0] quo_p;
    logic [W-1:0]  den_p;
    logic [W:0]    r2;
    logic          ge;
    logic [W:0]    r_sub;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = {num_i, {FRAC_BITS{1'b0}}};
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
      assign den_p = den_q[k-1];
    end

    assign r2    = {rem_p, num_p[NQ-1]};
    assign ge    = r2 >= {1'b0, den_p};
    assign r_sub = ge ? (r2 - {1'b0, den_p}) : r2;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= r_sub[W-1:0];
        num_q[k] <= {num_p[NQ-2:0], 1'b0};
        quo_q[k] <= {quo_p[NQ-2:0], ge};
        den_q[k] <= den_p;
      end
    end
  end

  assign quo_o = quo_q[NQ-1];

endmodule
`default_nettype wire

// ----- rtl/ray_box_slab_test.sv -----
// Ray versus axis-aligned box hit test (slab method), top level.
// Uses rbst_pkg, rbst_div and ray_box_slab_test_macros.svh.
//
// Input channel: one ray per beat (origin and direction, signed Q8.16),
// accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one hit flag per ray, in order, taken when out_valid_o is
// high and out_stall_i is low.
// Box corners live in six APB registers at byte addresses 0, 4, .. 20;
// write them only while no ray is in flight.
// Stages: prep, the divider stages, then saturate, order, xy and output.
// The six quotients run in bit-serial divider pipelines, one bit per
// stage. Throughput: one ray per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline and raises in_stall_o in the
// same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default box corners.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_box_slab_test_macros.svh"
module ray_box_slab_test #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbst_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o
);
  import rbst_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int NQ   = W + FRAC_BITS;
  localparam int NSTG = NQ + 5;
  localparam int S_SAT = NQ + 1;
  localparam int S_ORD = NQ + 2;
  localparam int S_XY  = NQ + 3;
  localparam int S_OUT = NQ + 4;
  localparam logic [NQ:0] LIM_POS = (NQ+1)'(64'h7FFF_FFFF);
  localparam logic [NQ:0] LIM_NEG = (NQ+1)'(64'h8000_0000);

  // configuration
  logic signed [W-1:0] corner_q [NUM_REGS];
  logic                wr_en;
  reg_idx_e            wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) corner_q[i] <= W'(CORNER_RST[i]);
    end else if (wr_en) begin
      case (wr_idx)
        REG_A_X: corner_q[0] <= pwdata[W-1:0];
        REG_A_Y: corner_q[1] <= pwdata[W-1:0];
        REG_A_Z: corner_q[2] <= pwdata[W-1:0];
        REG_B_X: corner_q[3] <= pwdata[W-1:0];
        REG_B_Y: corner_q[4] <= pwdata[W-1:0];
        REG_B_Z: corner_q[5] <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_A_X: prdata = 32'(corner_q[0]);
      REG_A_Y: prdata = 32'(corner_q[1]);
      REG_A_Z: prdata = 32'(corner_q[2]);
      REG_B_X: prdata = 32'(corner_q[3]);
      REG_B_Y: prdata = 32'(corner_q[4]);
      REG_B_Z: prdata = 32'(corner_q[5]);
      default: prdata = '0;
    endcase
  end

  // pipeline control
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en          = !vld_q[S_OUT] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[S_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // prep stage: differences, magnitudes, zero-direction handling
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic [W-1:0]        mag_a_d [3];
  logic [W-1:0]        mag_b_d [3];
  logic [W-1:0]        den_d [3];
  logic [W-1:0]        mag_a_q [3];
  logic [W-1:0]        mag_b_q [3];
  logic [W-1:0]        den_q [3];
  side_t               side_d;
  side_t               side_q [NQ+1];

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  always_comb begin
    logic signed [W:0]   da;
    logic signed [W:0]   db;
    logic signed [W:0]   nd;
    logic signed [W-1:0] ca;
    logic signed [W-1:0] cb;
    logic signed [W-1:0] smin;
    logic signed [W-1:0] smax;
    logic                zero;
    side_d = '0;
    for (int i = 0; i < 3; i++) begin
      ca   = corner_q[i];
      cb   = corner_q[i+3];
      da   = (W+1)'(ca) - (W+1)'(org[i]);
      db   = (W+1)'(cb) - (W+1)'(org[i]);
      nd   = -((W+1)'(dir[i]));
      mag_a_d[i] = da[W] ? W'(-da) : da[W-1:0];
      mag_b_d[i] = db[W] ? W'(-db) : db[W-1:0];
      den_d[i]   = dir[i][W-1] ? nd[W-1:0] : dir[i];
      zero = dir[i] == '0;
      smin = (ca < cb) ? ca : cb;
      smax = (ca < cb) ? cb : ca;
      side_d.neg_a[i] = da[W] ^ dir[i][W-1];
      side_d.neg_b[i] = db[W] ^ dir[i][W-1];
      side_d.unb[i]   = zero;
      side_d.miss[i]  = zero && ((org[i] < smin) || (org[i] > smax));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_a_q   <= mag_a_d;
      mag_b_q   <= mag_b_d;
      den_q     <= den_d;
      side_q[0] <= side_d;
      for (int k = 1; k <= NQ; k++) side_q[k] <= side_q[k-1];
    end
  end

  // dividers
  logic [NQ-1:0] quo_a [3];
  logic [NQ-1:0] quo_b [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rbst_div #(.W(W)) u_div_a (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (mag_a_q[i]),
      .den_i (den_q[i]),
      .quo_o (quo_a[i])
    );
    rbst_div #(.W(W)) u_div_b (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (mag_b_q[i]),
      .den_i (den_q[i]),
      .quo_o (quo_b[i])
    );
  end

  function automatic logic signed [32:0] sat_t(logic [NQ-1:0] mag, logic neg);
    logic [NQ:0] m;
    m = {1'b0, mag};
    if (!neg) begin
      return (m > LIM_POS) ? T_MAX : {1'b0, m[31:0]};
    end
    return (m > LIM_NEG) ? T_MIN : -({1'b0, m[31:0]});
  endfunction

  // saturate, order, narrow
  logic signed [32:0] t0_q [3];
  logic signed [32:0] t1_q [3];
  logic [2:0]         miss_sat_q;
  logic signed [32:0] lo_q [3];
  logic signed [32:0] hi_q [3];
  logic [2:0]         miss_ord_q;
  logic signed [32:0] tmin_q;
  logic signed [32:0] tmax_q;
  logic signed [32:0] loz_q;
  logic signed [32:0] hiz_q;
  logic               miss_xy_q;
  logic               miss_z_q;
  logic               hit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (side_q[NQ].unb[i]) begin
          t0_q[i] <= T_UNB_LO;
          t1_q[i] <= T_UNB_HI;
        end else begin
          t0_q[i] <= sat_t(quo_a[i], side_q[NQ].neg_a[i]);
          t1_q[i] <= sat_t(quo_b[i], side_q[NQ].neg_b[i]);
        end
        lo_q[i] <= (t0_q[i] > t1_q[i]) ? t1_q[i] : t0_q[i];
        hi_q[i] <= (t0_q[i] > t1_q[i]) ? t0_q[i] : t1_q[i];
      end
      miss_sat_q <= side_q[NQ].miss;
      miss_ord_q <= miss_sat_q;

      miss_xy_q <= miss_ord_q[0] || miss_ord_q[1] ||
                   (lo_q[0] > hi_q[1]) || (lo_q[1] > hi_q[0]);
      tmin_q    <= (lo_q[1] > lo_q[0]) ? lo_q[1] : lo_q[0];
      tmax_q    <= (hi_q[1] < hi_q[0]) ? hi_q[1] : hi_q[0];
      loz_q     <= lo_q[2];
      hiz_q     <= hi_q[2];
      miss_z_q  <= miss_ord_q[2];

      hit_q <= !(miss_xy_q || miss_z_q || (tmin_q > hiz_q) || (loz_q > tmax_q));
    end
  end

  assign hit_o = hit_q;

  `RBST_ASSERT(a_freeze, clk_i, rst_ni, !en |=> $stable(vld_q), "pipeline moved while stalled")
  `RBST_ASSERT(a_enter, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> vld_q[0], "accepted beat lost at entry")
  `RBST_ASSERT_NR(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule
`default_nettype wire
